[hw/rtl/lcsp_pkg.sv]
// lcsp_pkg: transaction structs, operation/status codes and FSM states for the
// LRU capable server picker. No dependencies.
package lcsp_pkg;

  localparam int OP_W     = 2;
  localparam int SIG_W    = 6;
  localparam int SERVER_W = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_LOCATE   = 2'd1,
    OP_REMOVE   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SIG_W-1:0]    signature_id;
    logic [SERVER_W-1:0] server_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SERVER_W-1:0] chosen_server;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REG_CHK,
    ST_LOC_ROW,
    ST_LOC_SCAN,
    ST_FIND,
    ST_SHIFT,
    ST_TAIL,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/lcsp_ram.sv]
// lcsp_ram: generic simple dual-port RAM, one write port, one read port with
// registered read data. No dependencies.
module lcsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/lru_capable_server_picker_core.sv]
// LRU capable server picker: capability table RAM, recency order RAM, sequencer.
// Depends on lcsp_pkg and lcsp_ram.
// One transaction at a time; scan and shift walk the order entries in use.
// After reset a clearing pass zeroes every capability RAM row; req_ready is low
// during that pass.
module lru_capable_server_picker_core #(
  parameter int SERVERS    = 16,
  parameter int SIGNATURES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lcsp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lcsp_pkg::rsp_t rsp
);
  import lcsp_pkg::*;

  localparam int IDX_W     = $clog2(SERVERS);
  localparam int CNT_W     = $clog2(SERVERS + 1);
  localparam int SIG_IDX_W = $clog2(SIGNATURES);
  localparam logic [SERVERS-1:0]   ONE_HOT0 = SERVERS'(1);
  localparam logic [SIG_IDX_W-1:0] LAST_SIG = SIG_IDX_W'(SIGNATURES - 1);
  localparam logic [CNT_W-1:0]     FULL_LEN = CNT_W'(SERVERS);

  state_t               state, state_next;
  logic [OP_W-1:0]      op, op_next;
  logic [SIG_IDX_W-1:0] sig_addr, sig_addr_next;
  logic [IDX_W-1:0]     target, target_next;
  logic [SERVERS-1:0]   row, row_next;
  logic [IDX_W-1:0]     scan_idx, scan_idx_next;
  logic [CNT_W-1:0]     length, length_next;
  logic [SERVERS-1:0]   in_order, in_order_next;
  logic [SIG_IDX_W-1:0] sweep_idx, sweep_idx_next;
  logic [STATUS_W-1:0]  status, status_next;
  logic [IDX_W-1:0]     chosen, chosen_next;
  rsp_t                 rsp_next;
  logic                 rsp_valid_next;

  logic                 cap_we;
  logic [SIG_IDX_W-1:0] cap_waddr, cap_raddr;
  logic [SERVERS-1:0]   cap_wdata, cap_rdata;
  logic                 ord_we;
  logic [IDX_W-1:0]     ord_waddr, ord_raddr;
  logic [IDX_W-1:0]     ord_wdata, entry;

  logic                 srv_ok, sig_ok;
  logic [IDX_W-1:0]     req_srv;
  logic [CNT_W-1:0]     scan_nxt_cnt;
  logic [SERVERS-1:0]   tgt_mask;

  lcsp_ram #(.WIDTH(SERVERS), .DEPTH(SIGNATURES)) u_cap_ram (
    .clk     (clk),
    .wr_en   (cap_we),
    .wr_addr (cap_waddr),
    .wr_data (cap_wdata),
    .rd_addr (cap_raddr),
    .rd_data (cap_rdata)
  );

  lcsp_ram #(.WIDTH(IDX_W), .DEPTH(SERVERS)) u_ord_ram (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (ord_waddr),
    .wr_data (ord_wdata),
    .rd_addr (ord_raddr),
    .rd_data (entry)
  );

  assign srv_ok       = int'(req.server_id) < SERVERS;
  assign sig_ok       = int'(req.signature_id) < SIGNATURES;
  assign req_srv      = IDX_W'(req.server_id);
  assign scan_nxt_cnt = CNT_W'(scan_idx) + CNT_W'(1);
  assign tgt_mask     = ONE_HOT0 << target;
  assign req_ready    = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    op_next        = op;
    sig_addr_next  = sig_addr;
    target_next    = target;
    row_next       = row;
    scan_idx_next  = scan_idx;
    length_next    = length;
    in_order_next  = in_order;
    sweep_idx_next = sweep_idx;
    status_next    = status;
    chosen_next    = chosen;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    cap_we         = 1'b0;
    cap_waddr      = sig_addr;
    cap_wdata      = row;
    cap_raddr      = sig_addr;
    ord_we         = 1'b0;
    ord_waddr      = scan_idx;
    ord_wdata      = target;
    ord_raddr      = scan_idx;

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_INIT: begin
        cap_we    = 1'b1;
        cap_waddr = sweep_idx;
        cap_wdata = '0;
        if (sweep_idx == LAST_SIG) begin
          sweep_idx_next = '0;
          state_next     = ST_IDLE;
        end else begin
          sweep_idx_next = sweep_idx + SIG_IDX_W'(1);
        end
      end
      ST_IDLE: begin
        cap_raddr = SIG_IDX_W'(req.signature_id);
        ord_raddr = '0;
        if (req_valid) begin
          op_next        = req.operation;
          sig_addr_next  = SIG_IDX_W'(req.signature_id);
          target_next    = req_srv;
          status_next    = STATUS_OK;
          chosen_next    = '0;
          scan_idx_next  = '0;
          sweep_idx_next = '0;
          case (req.operation)
            OP_REGISTER: begin
              state_next = (srv_ok && sig_ok) ? ST_REG_CHK : ST_DONE;
            end
            OP_LOCATE: begin
              if (sig_ok) begin
                state_next = ST_LOC_ROW;
              end else begin
                status_next = STATUS_NONE;
                state_next  = ST_DONE;
              end
            end
            OP_REMOVE: begin
              cap_raddr = '0;
              if (!srv_ok) begin
                state_next = ST_DONE;
              end else if (in_order[req_srv]) begin
                state_next = ST_FIND;
              end else begin
                state_next = ST_SWEEP;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_REG_CHK: begin
        if ((cap_rdata & tgt_mask) != '0) begin
          status_next = STATUS_DUP;
          state_next  = ST_DONE;
        end else begin
          cap_we    = 1'b1;
          cap_waddr = sig_addr;
          cap_wdata = cap_rdata | tgt_mask;
          if (in_order[target]) begin
            ord_raddr     = '0;
            scan_idx_next = '0;
            state_next    = ST_FIND;
          end else begin
            if (length < FULL_LEN) begin
              ord_we                = 1'b1;
              ord_waddr             = IDX_W'(length);
              ord_wdata             = target;
              length_next           = length + CNT_W'(1);
              in_order_next[target] = 1'b1;
            end
            state_next = ST_DONE;
          end
        end
      end
      ST_LOC_ROW: begin
        row_next  = cap_rdata;
        ord_raddr = '0;
        if (length == '0) begin
          status_next = STATUS_NONE;
          state_next  = ST_DONE;
        end else begin
          state_next = ST_LOC_SCAN;
        end
      end
      ST_LOC_SCAN, ST_FIND: begin
        ord_raddr = IDX_W'(scan_nxt_cnt);
        if ((state == ST_LOC_SCAN && row[entry]) || (state == ST_FIND && entry == target)) begin
          target_next = entry;
          if (state == ST_LOC_SCAN) begin
            chosen_next = entry;
          end
          if (scan_nxt_cnt < length) begin
            scan_idx_next = scan_idx + IDX_W'(1);
            state_next    = ST_SHIFT;
          end else begin
            state_next = ST_TAIL;
          end
        end else if (scan_nxt_cnt >= length) begin
          status_next = STATUS_NONE;
          state_next  = ST_DONE;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        ord_we    = 1'b1;
        ord_waddr = scan_idx - IDX_W'(1);
        ord_wdata = entry;
        ord_raddr = IDX_W'(scan_nxt_cnt);
        if (scan_nxt_cnt < length) begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (op == OP_REMOVE) begin
          length_next           = length - CNT_W'(1);
          in_order_next[target] = 1'b0;
          cap_raddr             = '0;
          sweep_idx_next        = '0;
          state_next            = ST_SWEEP;
        end else begin
          ord_we     = 1'b1;
          ord_waddr  = IDX_W'(length - CNT_W'(1));
          ord_wdata  = target;
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cap_we    = 1'b1;
        cap_waddr = sweep_idx;
        cap_wdata = cap_rdata & ~tgt_mask;
        cap_raddr = sweep_idx + SIG_IDX_W'(1);
        if (sweep_idx == LAST_SIG) begin
          state_next = ST_DONE;
        end else begin
          sweep_idx_next = sweep_idx + SIG_IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next         = 1'b1;
          rsp_next.status        = status;
          rsp_next.chosen_server = SERVER_W'(chosen);
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep_idx <= '0;
      length    <= '0;
      in_order  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
      length    <= length_next;
      in_order  <= in_order_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    sig_addr <= sig_addr_next;
    target   <= target_next;
    row      <= row_next;
    scan_idx <= scan_idx_next;
    status   <= status_next;
    chosen   <= chosen_next;
    rsp      <= rsp_next;
  end

endmodule

[tb/lcsp_rsp_checker.sv]
// lcsp_rsp_checker: watches both channels of the server picker, predicts each response
// from its own copy of the capability table and recency order, and compares field by field.
// Depends on lcsp_pkg.
module lcsp_rsp_checker #(
  parameter int SERVERS    = 16,
  parameter int SIGNATURES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  lcsp_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  lcsp_pkg::rsp_t rsp,
  output int             in_flight,
  output int             errors,
  output int             responses,
  output int             locate_hits,
  output int             dup_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcsp_pkg::*;

  logic [SERVERS-1:0]  cap_rows [SIGNATURES];
  logic [SERVER_W-1:0] lru_order [SERVERS];
  logic [SERVERS-1:0]  in_lru;
  int                  lru_len;
  rsp_t                awaited_rsp [$];
  int                  fail_count = 0;
  int                  rsp_count = 0;
  int                  hit_count = 0;
  int                  dup_count = 0;

  assign errors      = fail_count;
  assign responses   = rsp_count;
  assign locate_hits = hit_count;
  assign dup_hits    = dup_count;

  task automatic report(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void lru_drop(logic [SERVER_W-1:0] srv);
    int pos;
    if (!in_lru[srv]) return;
    pos = lru_len;
    for (int i = 0; i < lru_len; i++) begin
      if (lru_order[i] == srv && pos == lru_len) pos = i;
    end
    if (pos < lru_len) begin
      for (int i = pos; i + 1 < lru_len; i++) lru_order[i] = lru_order[i+1];
      lru_len--;
    end
    in_lru[srv] = 1'b0;
  endfunction

  function automatic void lru_append(logic [SERVER_W-1:0] srv);
    if (lru_len < SERVERS) begin
      lru_order[lru_len] = srv;
      lru_len++;
      in_lru[srv] = 1'b1;
    end
  endfunction

  // Applies one request to the shadow tables and returns the response it should give.
  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    logic found;
    o = '0;
    found = 1'b0;
    case (r.operation)
      OP_REGISTER: begin
        if (cap_rows[r.signature_id][r.server_id]) begin
          o.status = STATUS_DUP;
          dup_count++;
        end else begin
          cap_rows[r.signature_id][r.server_id] = 1'b1;
          lru_drop(r.server_id);
          lru_append(r.server_id);
        end
      end
      OP_LOCATE: begin
        for (int i = 0; i < lru_len; i++) begin
          if (!found && cap_rows[r.signature_id][lru_order[i]]) begin
            found = 1'b1;
            o.chosen_server = lru_order[i];
          end
        end
        if (found) begin
          lru_drop(o.chosen_server);
          lru_append(o.chosen_server);
          hit_count++;
        end else begin
          o.status = STATUS_NONE;
          o.chosen_server = '0;
        end
      end
      OP_REMOVE: begin
        lru_drop(r.server_id);
        for (int i = 0; i < SIGNATURES; i++) cap_rows[i][r.server_id] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SIGNATURES; i++) cap_rows[i] = '0;
      for (int i = 0; i < SERVERS; i++) lru_order[i] = '0;
      in_lru = '0;
      lru_len = 0;
      awaited_rsp.delete();
    end else begin
      if (req_valid && req_ready) awaited_rsp.push_back(serve_request(req));
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (awaited_rsp.size() == 0) begin
          report("unexpected response, status", rsp.status, -1);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.chosen_server !== want.chosen_server)
            report("chosen_server", rsp.chosen_server, want.chosen_server);
        end
      end
    end
    in_flight <= awaited_rsp.size();
  end

endmodule

[tb/tb_lru_capable_server_picker_core.sv]
// tb_lru_capable_server_picker_core: stimulus and verdict for the LRU server picker core.
// Drives directed and random register/locate/remove traffic with random gaps on both
// channels; depends on lcsp_pkg, the core and lcsp_rsp_checker.
module tb_lru_capable_server_picker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lcsp_pkg::*;

  localparam int SERVERS        = 16;
  localparam int SIGNATURES     = 64;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic no_idle = 1'b0;
  int   rsp_hold = 0;
  int   quiet_cycles = 0;
  int   op_count [4] = '{0, 0, 0, 0};
  int   in_flight, errors, responses, locate_hits, dup_hits;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lru_capable_server_picker_core #(
    .SERVERS    (SERVERS),
    .SIGNATURES (SIGNATURES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lcsp_rsp_checker #(
    .SERVERS    (SERVERS),
    .SIGNATURES (SIGNATURES)
  ) i_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .in_flight   (in_flight),
    .errors      (errors),
    .responses   (responses),
    .locate_hits (locate_hits),
    .dup_hits    (dup_hits)
  );

  // Response side: random stall after each transaction, except while no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_hold  = 0;
    end else if (rsp_valid && rsp_ready) begin
      rsp_hold  = no_idle ? 0 : $urandom_range(0, 9);
      rsp_ready <= (rsp_hold == 0);
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_ready <= (rsp_hold == 0);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
               quiet_cycles, in_flight);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t request(logic [OP_W-1:0] op, int sig, int srv);
    req_t r;
    r.operation    = op;
    r.signature_id = SIG_W'(sig);
    r.server_id    = SERVER_W'(srv);
    return r;
  endfunction

  // Mostly a small pool of signatures so that locates find servers.
  function automatic req_t random_request();
    int pick;
    int sig;
    pick = $urandom_range(0, 99);
    sig  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SIGNATURES - 1) : $urandom_range(0, 7);
    if (pick < 42)      return request(OP_REGISTER, sig, $urandom_range(0, SERVERS - 1));
    else if (pick < 78) return request(OP_LOCATE, sig, $urandom_range(0, SERVERS - 1));
    else if (pick < 94) return request(OP_REMOVE, sig, $urandom_range(0, SERVERS - 1));
    else                return request(OP_UNUSED, sig, $urandom_range(0, SERVERS - 1));
  endfunction

  // Valid stays high across back-to-back transactions; lowered only for a gap or while draining.
  task automatic send_item(req_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    op_count[item.operation]++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  initial begin
    int   sent;
    req_t item;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(request(OP_LOCATE, 0, 0));
    send_item(request(OP_REGISTER, 0, 0));
    send_item(request(OP_REGISTER, 0, 0));
    send_item(request(OP_REGISTER, 63, 15));
    send_item(request(OP_REGISTER, 63, 15));
    send_item(request(OP_REGISTER, 0, 15));
    send_item(request(OP_LOCATE, 0, 0));
    send_item(request(OP_LOCATE, 0, 0));
    send_item(request(OP_LOCATE, 63, 15));
    send_item(request(OP_UNUSED, 63, 15));
    send_item(request(OP_UNUSED, 0, 0));
    send_item(request(OP_REMOVE, 0, 9));
    send_item(request(OP_REGISTER, 42, 5));
    send_item(request(OP_REGISTER, 21, 10));
    send_item(request(OP_LOCATE, 21, 0));
    send_item(request(OP_REMOVE, 63, 15));
    send_item(request(OP_LOCATE, 63, 0));
    send_item(request(OP_REMOVE, 0, 0));
    send_item(request(OP_LOCATE, 0, 15));
    send_item(request(OP_LOCATE, 42, 0));
    send_item(request(OP_REGISTER, 42, 10));
    send_item(request(OP_LOCATE, 42, 0));
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      no_idle <= ((sent / 50) % 4 == 2);
      item = random_request();
      send_item(item);
      if (item.operation != OP_UNUSED) begin
        sent++;
        if (sent == RANDOM_ITEMS / 2) wait_drained();
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d register, %0d locate, %0d remove and %0d unused-op transactions",
             op_count[OP_REGISTER], op_count[OP_LOCATE], op_count[OP_REMOVE],
             op_count[OP_UNUSED]);
    $display("%0d responses checked: %0d locates found a server, %0d duplicate registers",
             responses, locate_hits, dup_hits);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lcsp_pkg.sv
hw/rtl/lcsp_ram.sv
hw/rtl/lru_capable_server_picker_core.sv
tb/lcsp_rsp_checker.sv
tb/tb_lru_capable_server_picker_core.sv
